// ===== rtl/urav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urav_pkg
// Shared types and constants for the ultrasonic range averager.
// ----------------------------------------------------------------------------
package urav_pkg;

	// register widths
	localparam int CountW   = 8;
	localparam int TrigW    = 10;
	localparam int TimeoutW = 16;
	localparam int PeriodW  = 17;
	localparam int UpcW     = 8;
	localparam int SumW     = 24;
	localparam int DistW    = 25;
	localparam int TicksW   = 17;

	// configuration port
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 17;

	// divider: numerator is sum * 256, denominator is rounds * us_per_cm
	localparam int NumW    = SumW + 8;
	localparam int DenW    = CountW + UpcW;
	localparam int DivCntW = $clog2(NumW);

	localparam logic [PeriodW-1:0] PeriodMax = {PeriodW{1'b1}};

	// register indexes
	localparam logic [CfgIdxW-1:0] RegSampleCount  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegTriggerUs    = 3'd1;
	localparam logic [CfgIdxW-1:0] RegEchoTimeout  = 3'd2;
	localparam logic [CfgIdxW-1:0] RegTimeoutWidth = 3'd3;
	localparam logic [CfgIdxW-1:0] RegSamplePeriod = 3'd4;
	localparam logic [CfgIdxW-1:0] RegUsPerCm      = 3'd5;

	// measurement phase
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_TRIG = 3'd1,
		PH_WAIT = 3'd2,
		PH_HIGH = 3'd3,
		PH_HOLD = 3'd4
	} urav_phase_t;

	// sequencer state
	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DIV_LOAD,
		S_DIV,
		S_PUSH
	} urav_state_t;

	typedef struct packed {
		logic in_load;
		logic tick_commit;
		logic div_load;
		logic div_step;
		logic out_load;
	} urav_cmd_t;

	typedef struct packed {
		logic tick_done;
		logic div_last;
		logic out_free;
	} urav_sts_t;

endpackage

// ===== rtl/urav_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urav channel interfaces
// Tick input, result output and register write channels.
// ----------------------------------------------------------------------------

// one word per microsecond tick
interface urav_in_if import urav_pkg::*; ();
	logic valid;
	logic ready;
	logic start_req;
	logic echo_level;

	modport source (output valid, output start_req, output echo_level, input ready);
	modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

// one result word per tick
interface urav_out_if import urav_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             trigger_level;
	logic             busy_res;
	logic             done_res;
	logic [DistW-1:0] distance_q8;

	modport source (output valid, output trigger_level, output busy_res, output done_res,
		output distance_q8, input ready);
	modport sink (input valid, input trigger_level, input busy_res, input done_res,
		input distance_q8, output ready);
endinterface

// register writes
interface urav_cfg_if import urav_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/urav_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urav_ctrl
// Sequencer: takes a tick word, evaluates it, runs the divider on the
// done tick and hands the result word to the output register.
// ----------------------------------------------------------------------------
module urav_ctrl import urav_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  urav_sts_t sts,
	output urav_cmd_t cmd
);

	urav_state_t state_q, state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_load = in_valid;
				if (in_valid) begin
					state_n = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.tick_commit = 1'b1;
				state_n = sts.tick_done ? S_DIV_LOAD : S_PUSH;
			end
			S_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				state_n = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_n = S_PUSH;
				end
			end
			S_PUSH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/urav_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urav_datapath
// Registers, per-tick phase logic, restoring divider and output register.
// ----------------------------------------------------------------------------
module urav_datapath import urav_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  urav_cmd_t           cmd,
	output urav_sts_t           sts,
	input  logic                in_start,
	input  logic                in_echo,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                out_trig,
	output logic                out_busy,
	output logic                out_done,
	output logic [DistW-1:0]    out_dist
);

	// configuration registers
	logic [CountW-1:0]   sample_count_q;
	logic [TrigW-1:0]    trigger_us_q;
	logic [TimeoutW-1:0] echo_timeout_q;
	logic [TimeoutW-1:0] timeout_width_q;
	logic [PeriodW-1:0]  sample_period_q;
	logic [UpcW-1:0]     us_per_cm_q;

	// measurement state
	urav_phase_t       phase_q;
	logic [TicksW-1:0] phase_ticks_q;
	logic [PeriodW-1:0] period_q;
	logic [CountW-1:0] rounds_q;
	logic [SumW-1:0]   sum_q;
	logic [DistW-1:0]  last_dist_q;

	// captured tick word and pending result flags
	logic start_q, echo_q;
	logic trig_q, busy_q, done_q;

	// divider
	logic [NumW-1:0]     num_q;
	logic [DenW-1:0]     den_q;
	logic [DenW-1:0]     rem_q;
	logic [DivCntW-1:0]  div_cnt_q;
	logic [DenW:0]       rem_sh;
	logic [DenW:0]       rem_diff;
	logic                rem_ge;
	logic [NumW-1:0]     num_n;

	// output register
	logic             out_valid_q;
	logic             out_trig_q, out_busy_q, out_done_q;
	logic [DistW-1:0] out_dist_q;

	// next tick values
	urav_phase_t        ph_n;
	logic [TicksW-1:0]  pt_n;
	logic [PeriodW-1:0] per_n;
	logic [CountW-1:0]  rd_n;
	logic [SumW-1:0]    ws_n;
	logic               trig_n, busy_n, done_n;
	logic               end_rnd;
	logic [TimeoutW-1:0] end_w;
	logic [CountW-1:0]  want;
	logic [UpcW-1:0]    upc;

	assign want = (sample_count_q == '0) ? CountW'(1) : sample_count_q;
	assign upc  = (us_per_cm_q == '0) ? UpcW'(1) : us_per_cm_q;

	// one tick of the ranging sequence
	always_comb begin
		ph_n    = phase_q;
		pt_n    = phase_ticks_q;
		per_n   = period_q;
		rd_n    = rounds_q;
		ws_n    = sum_q;
		trig_n  = 1'b0;
		busy_n  = 1'b0;
		done_n  = 1'b0;
		end_rnd = 1'b0;
		end_w   = '0;
		if (phase_q == PH_IDLE && start_q) begin
			ph_n  = PH_TRIG;
			pt_n  = '0;
			per_n = '0;
			rd_n  = '0;
			ws_n  = '0;
		end
		if (ph_n != PH_IDLE) begin
			busy_n = 1'b1;
			if (per_n != PeriodMax) begin
				per_n = per_n + PeriodW'(1);
			end
			case (ph_n)
				PH_TRIG: begin
					trig_n = 1'b1;
					pt_n   = pt_n + TicksW'(1);
					if (pt_n >= TicksW'(trigger_us_q)) begin
						ph_n = PH_WAIT;
						pt_n = '0;
					end
				end
				PH_WAIT: begin
					if (echo_q) begin
						ph_n = PH_HIGH;
						pt_n = TicksW'(1);
					end else begin
						pt_n = pt_n + TicksW'(1);
					end
					if (pt_n > TicksW'(echo_timeout_q)) begin
						end_rnd = 1'b1;
						end_w   = timeout_width_q;
					end
				end
				PH_HIGH: begin
					if (!echo_q) begin
						end_rnd = 1'b1;
						end_w   = pt_n[TimeoutW-1:0];
					end else begin
						pt_n = pt_n + TicksW'(1);
						if (pt_n > TicksW'(echo_timeout_q)) begin
							end_rnd = 1'b1;
							end_w   = timeout_width_q;
						end
					end
				end
				default: ;
			endcase
			if (end_rnd) begin
				ws_n = ws_n + SumW'(end_w);
				rd_n = rd_n + CountW'(1);
				ph_n = PH_HOLD;
			end
			// round spacing, then next round or report
			if (ph_n == PH_HOLD && per_n >= sample_period_q) begin
				if (rd_n >= want) begin
					done_n = 1'b1;
					busy_n = 1'b0;
					ph_n   = PH_IDLE;
				end else begin
					ph_n = PH_TRIG;
				end
				pt_n  = '0;
				per_n = '0;
			end
		end
	end

	// divider step: shift in one numerator bit, subtract when it fits
	assign rem_sh   = {rem_q, num_q[NumW-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign rem_ge   = (rem_sh >= {1'b0, den_q});
	assign num_n    = {num_q[NumW-2:0], rem_ge};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q  <= CountW'(2);
			trigger_us_q    <= TrigW'(10);
			echo_timeout_q  <= TimeoutW'(30000);
			timeout_width_q <= TimeoutW'(17400);
			sample_period_q <= PeriodW'(60000);
			us_per_cm_q     <= UpcW'(58);
		end else if (cfg_we) begin
			case (cfg_index)
				RegSampleCount:  sample_count_q  <= cfg_data[CountW-1:0];
				RegTriggerUs:    trigger_us_q    <= cfg_data[TrigW-1:0];
				RegEchoTimeout:  echo_timeout_q  <= cfg_data[TimeoutW-1:0];
				RegTimeoutWidth: timeout_width_q <= cfg_data[TimeoutW-1:0];
				RegSamplePeriod: sample_period_q <= cfg_data[PeriodW-1:0];
				RegUsPerCm:      us_per_cm_q     <= cfg_data[UpcW-1:0];
				default: ;
			endcase
		end
	end

	// measurement state and reported distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			phase_ticks_q <= '0;
			period_q      <= '0;
			rounds_q      <= '0;
			sum_q         <= '0;
			last_dist_q   <= '0;
		end else begin
			if (cmd.tick_commit) begin
				phase_q       <= ph_n;
				phase_ticks_q <= pt_n;
				period_q      <= per_n;
				rounds_q      <= rd_n;
				sum_q         <= ws_n;
			end
			if (cmd.div_step && sts.div_last) begin
				last_dist_q <= num_n[DistW-1:0];
			end
		end
	end

	// captured tick word and result flags
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			start_q <= in_start;
			echo_q  <= in_echo;
		end
		if (cmd.tick_commit) begin
			trig_q <= trig_n;
			busy_q <= busy_n;
			done_q <= done_n;
		end
	end

	// divider registers
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q     <= {sum_q, 8'd0};
			den_q     <= DenW'(rounds_q) * DenW'(upc);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			num_q     <= num_n;
			rem_q     <= rem_ge ? rem_diff[DenW-1:0] : rem_sh[DenW-1:0];
			div_cnt_q <= div_cnt_q + DivCntW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_trig_q <= trig_q;
			out_busy_q <= busy_q;
			out_done_q <= done_q;
			out_dist_q <= last_dist_q;
		end
	end

	assign sts.tick_done = done_n;
	assign sts.div_last  = (div_cnt_q == DivCntW'(NumW - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_trig  = out_trig_q;
	assign out_busy  = out_busy_q;
	assign out_done  = out_done_q;
	assign out_dist  = out_dist_q;

endmodule

// ===== rtl/ultrasonic_range_averager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_averager
// Ultrasonic ranging sequencer that averages several echo widths.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one word per microsecond tick: start_req and the sampled
//   echo pin. For every tick word one result word leaves on out_ch with the
//   trigger pin level, busy, done and the distance in cm (Q8).
//   cfg writes the six registers by index and is always ready; the user
//   must write it only while no tick word is in flight, unchecked by the block.
// Sequence:
//   a tick word passes three steps from acceptance to the result register
//   (accept, evaluate, load). On the tick that reports a distance the
//   restoring divider adds a load step and then one quotient bit per cycle
//   over 32 bits. One word is in work at a time; the next is taken while
//   the previous result waits on out_ch.
// Reset:
//   arst_n clears the sequencer, the measurement state and the reported
//   distance, and loads the register defaults.
// Stall:
//   a result word holds on out_ch until taken; the sequencer then waits
//   with its next result and does not take further tick words.
// ----------------------------------------------------------------------------
module ultrasonic_range_averager import urav_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	urav_in_if.sink           in_ch,
	urav_out_if.source        out_ch,
	urav_cfg_if.sink          cfg
);

	urav_cmd_t cmd;
	urav_sts_t sts;
	logic      in_ready;

	assign in_ch.ready = in_ready;
	assign cfg.ready   = 1'b1;

	// sequencer
	urav_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	urav_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_start  (in_ch.start_req),
		.in_echo   (in_ch.echo_level),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_trig  (out_ch.trigger_level),
		.out_busy  (out_ch.busy_res),
		.out_done  (out_ch.done_res),
		.out_dist  (out_ch.distance_q8)
	);

endmodule

// ===== rtl/urav_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urav_checker
// Port-level checks on the result channel of the range averager.
// ----------------------------------------------------------------------------
module urav_checker import urav_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic             trigger_level,
	input logic             busy_res,
	input logic             done_res,
	input logic [DistW-1:0] distance_q8
);

	// no result word during reset
	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result word valid during reset");

	// done word closes the measurement, so busy is low on it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && busy_res))
		else $error("done and busy both set");

	// trigger only driven inside a measurement
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger_level |-> busy_res)
		else $error("trigger high while not busy");

	// stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(trigger_level)
			&& $stable(busy_res) && $stable(done_res) && $stable(distance_q8))
		else $error("stalled result word changed");

endmodule

bind ultrasonic_range_averager urav_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.trigger_level (out_ch.trigger_level),
	.busy_res      (out_ch.busy_res),
	.done_res      (out_ch.done_res),
	.distance_q8   (out_ch.distance_q8)
);
